// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, not gated by reset.
`define ASSERT_IMPL(lbl, clk, ant, cons) \
    lbl: assert property (@(posedge clk) (ant) |-> (cons)) \
        else $error("assertion failed");

// Same-cycle implication, gated while reset (active low) is asserted.
`define ASSERT_IMPL_RST(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated while reset (active low) is asserted.
`define ASSERT_NEXT_RST(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/fdss_pkg.sv -----
// ----------------------------------------------------------------------------
// fdss_pkg
// Types, constants and lookup functions of the seven-segment serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package fdss_pkg;

    localparam int VALUE_W       = 14;
    localparam int FRAME_BITS    = 16;
    localparam int CNT_W         = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH   = 4;
    localparam int NUM_DIGITS    = 4;
    localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);

    localparam logic [VALUE_W-1:0] VALUE_WRAP = VALUE_W'(10000);

    // digit-select codes
    localparam logic [7:0] SEL_ONES      = 8'h01;
    localparam logic [7:0] SEL_TENS      = 8'h02;
    localparam logic [7:0] SEL_HUNDREDS  = 8'h04;
    localparam logic [7:0] SEL_THOUSANDS = 8'h08;
    localparam logic [7:0] SEG_BLANK     = 8'hFF;

    // digit indexes
    localparam logic [DIGIT_IDX_W-1:0] IDX_ONES      = DIGIT_IDX_W'(0);
    localparam logic [DIGIT_IDX_W-1:0] IDX_TENS      = DIGIT_IDX_W'(1);
    localparam logic [DIGIT_IDX_W-1:0] IDX_HUNDREDS  = DIGIT_IDX_W'(2);
    localparam logic [DIGIT_IDX_W-1:0] IDX_THOUSANDS = DIGIT_IDX_W'(3);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               show_leading_zeros;
    } fdss_in_t;

    typedef struct packed {
        logic data_bit;
        logic latch;
        logic last;
    } fdss_out_t;

    // one queued frame: segment byte, select byte, last frame of the pass
    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  last;
    } fdss_entry_t;

    typedef struct packed {
        logic        valid;
        fdss_entry_t entry;
    } fdss_slot_t;

    typedef enum logic [0:0] {
        FRONT_IDLE,
        FRONT_DIGIT
    } fdss_front_state_t;

    // active-low segment pattern of a decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] sel_of(input logic [DIGIT_IDX_W-1:0] idx);
        logic [7:0] sel;
        case (idx)
            IDX_ONES:      sel = SEL_ONES;
            IDX_TENS:      sel = SEL_TENS;
            IDX_HUNDREDS:  sel = SEL_HUNDREDS;
            IDX_THOUSANDS: sel = SEL_THOUSANDS;
            default:       sel = SEL_ONES;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fdss_queue.sv -----
// ----------------------------------------------------------------------------
// fdss_queue
// Small frame queue between the digit front end and the bit shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fdss_pkg::fdss_slot_t push_i,
    output logic                     full_o,
    input  wire logic                pop_i,
    output fdss_pkg::fdss_slot_t     head_o
);
    import fdss_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fdss_entry_t      entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full_o  = (count_reg == CNT_FULL);
    assign do_push = push_i.valid && !full_o;
    assign do_pop  = pop_i && (count_reg != '0);

    assign head_o.valid = (count_reg != '0);
    assign head_o.entry = entries_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_i.entry;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fdss_front.sv -----
// ----------------------------------------------------------------------------
// fdss_front
// Accepts a value, extracts one decimal digit per cycle (stalling only on a shown
// digit while the queue is full) and queues a frame for every digit that is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fdss_pkg::fdss_in_t  s_payload,
    output fdss_pkg::fdss_slot_t     push_o,
    input  wire logic                full_i
);
    import fdss_pkg::*;

    // x * 52429 >> 19 equals x / 10 for every x below 10000
    localparam logic [15:0] RECIP_TEN = 16'd52429;
    localparam int          RECIP_SH  = 19;
    localparam int          PROD_W    = VALUE_W + 16;

    fdss_front_state_t      state_reg, state_next;
    logic [VALUE_W-1:0]     rem_reg, rem_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [DIGIT_IDX_W-1:0] last_idx_reg, last_idx_next;

    logic [PROD_W-1:0]      prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     ten_quot;
    logic [3:0]             digit;
    logic                   shown;

    // divide by ten through the reciprocal, remainder is the digit
    assign prod     = PROD_W'(rem_reg) * PROD_W'(RECIP_TEN);
    assign quot     = VALUE_W'(prod >> RECIP_SH);
    assign ten_quot = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
    assign digit    = 4'(rem_reg - ten_quot);
    assign shown    = (idx_reg <= last_idx_reg);

    assign push_o.entry.frame = {seg_of(digit), sel_of(idx_reg)};
    assign push_o.entry.last  = (idx_reg == last_idx_reg);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        s_ready       = 1'b0;
        push_o.valid  = 1'b0;
        case (state_reg)
            FRONT_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    rem_next = (s_payload.value >= VALUE_WRAP) ?
                               s_payload.value - VALUE_WRAP : s_payload.value;
                    idx_next = IDX_ONES;
                    if (s_payload.show_leading_zeros ||
                        s_payload.value > VALUE_W'(999)) begin
                        last_idx_next = IDX_THOUSANDS;
                    end else if (s_payload.value > VALUE_W'(99)) begin
                        last_idx_next = IDX_HUNDREDS;
                    end else if (s_payload.value > VALUE_W'(9)) begin
                        last_idx_next = IDX_TENS;
                    end else begin
                        last_idx_next = IDX_ONES;
                    end
                    state_next = FRONT_DIGIT;
                end
            end
            FRONT_DIGIT: begin
                push_o.valid = shown;
                if (!shown || !full_i) begin
                    rem_next = quot;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_THOUSANDS) begin
                        state_next = FRONT_IDLE;
                    end
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
    end

endmodule

`default_nettype wire

// ----- sv/fdss_back.sv -----
// ----------------------------------------------------------------------------
// fdss_back
// Shifts queued frames out MSB first, one bit per beat, through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fdss_pkg::fdss_slot_t head_i,
    output logic                     pop_o,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fdss_pkg::fdss_out_t      m_payload
);
    import fdss_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  last_frame_reg, last_frame_next;
    logic                  out_valid_reg, out_valid_next;
    fdss_out_t             out_reg, out_next;
    logic                  advance, load, frame_end;

    assign advance   = busy_reg && (!out_valid_reg || m_ready);
    assign frame_end = (cnt_reg == CNT_LAST);
    assign load      = head_i.valid && (!busy_reg || (advance && frame_end));
    assign pop_o     = load;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // shifter and output slot
    always_comb begin
        frame_next      = frame_reg;
        cnt_next        = cnt_reg;
        busy_next       = busy_reg;
        last_frame_next = last_frame_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (advance) begin
            out_next.data_bit = frame_reg[FRAME_BITS-1];
            out_next.latch    = frame_end;
            out_next.last     = frame_end && last_frame_reg;
            out_valid_next    = 1'b1;
            frame_next        = {frame_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next          = cnt_reg + 1'b1;
            if (frame_end) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            frame_next      = head_i.entry.frame;
            last_frame_next = head_i.entry.last;
            cnt_next        = '0;
            busy_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg      <= frame_next;
        cnt_reg        <= cnt_next;
        last_frame_reg <= last_frame_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

// ----- sv/four_digit_seven_segment_serializer.sv -----
// ----------------------------------------------------------------------------
// four_digit_seven_segment_serializer
// Turns a 14-bit value, wrapped modulo 10000 to four decimal digits, into
// serial shift-register frames for a multiplexed seven-segment display.
// Usage:
//   s_ channel: one beat carries a value and the leading-zero flag.
//   m_ channel: one beat per shifted bit (data_bit, latch, last). A pass
//   is 16, 32, 48 or 64 beats: one 16-bit frame (segment byte, then
//   digit-select byte) per shown digit, ones digit first. latch marks the
//   sixteenth bit of every frame, last the final bit of the pass.
//   Path: front-end registers, frame queue, shift register, output register.
//   Throughput: one output bit per cycle while m_ready is high and the queue
//   holds frames. The front end takes a value in its accept state, then steps
//   through all four digit positions, shown or not; the next value is taken
//   while the previous pass is still shifting, as long as the frame queue
//   has room. The bit shifter sets the sustained rate.
//   Reset: synchronous, active low; clears queue, shifter and output slot.
//   Stall: when m_ready is low the output beat holds, the shifter stops,
//   the queue fills and then the front end stops taking values.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_seven_segment_serializer #(
    parameter int QUEUE_DEPTH = fdss_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fdss_pkg::fdss_in_t s_payload,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fdss_pkg::fdss_out_t     m_payload
);
    import fdss_pkg::*;

    fdss_slot_t push;
    fdss_slot_t head;
    logic       full;
    logic       pop;

    fdss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .push_o    (push),
        .full_i    (full)
    );

    fdss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .full_o  (full),
        .pop_i   (pop),
        .head_o  (head)
    );

    fdss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_i    (head),
        .pop_o     (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// ----- sv/fdss_checker.sv -----
// ----------------------------------------------------------------------------
// fdss_checker
// Port-level checks of the serializer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fdss_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire fdss_pkg::fdss_in_t  s_payload,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire fdss_pkg::fdss_out_t m_payload
);
    import fdss_pkg::*;

    logic in_beat;
    assign in_beat = s_valid && s_ready;

    // a stalled output beat holds its bit
    `ASSERT_NEXT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // the final bit of a pass always closes a frame
    `ASSERT_IMPL_RST(a_last_latch, aclk, aresetn, m_valid && m_payload.last, m_payload.latch)

    // nothing comes out in the cycle after reset, and input is open again
    `ASSERT_IMPL(a_reset_out, aclk, !$past(aresetn), !m_valid)
    `ASSERT_IMPL(a_reset_in, aclk, !$past(aresetn), s_ready)

    // a value is worked on through its digit positions before the next is taken
    `ASSERT_NEXT_RST(a_front_busy, aclk, aresetn, in_beat, !s_ready)

endmodule

bind four_digit_seven_segment_serializer fdss_checker u_fdss_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

// ----- sim/fdss_checker.sv -----
// ----------------------------------------------------------------------------
// fdss_scoreboard
// Scoreboard for the seven-segment serializer. Every accepted input beat is
// expanded into the serial bit stream of its display pass, and every output
// beat is compared against the oldest predicted bit.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_scoreboard (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire fdss_pkg::fdss_in_t  s_payload,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire fdss_pkg::fdss_out_t m_payload,
    output int                       mismatch_count,
    output int                       pending,
    output int                       beat_count
);
    import fdss_pkg::*;

    // active-low glyphs for digits 0..9, digit 0 in the low byte
    localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                      8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
    // digit-select byte per position, ones in the low byte
    localparam logic [31:0] SELECTS = {SEL_THOUSANDS, SEL_HUNDREDS, SEL_TENS, SEL_ONES};

    fdss_out_t expected_bits[$];
    fdss_out_t want;
    int        mismatches = 0;
    int        beats_seen = 0;

    // Expand one value into the bits of its pass, ones frame first.
    function automatic void predict_pass(input fdss_in_t beat);
        int          wrapped;
        int          divisor;
        int          shown;
        int          digit [4];
        logic [15:0] frame;
        fdss_out_t   one_bit;
        wrapped = int'(beat.value) % 10000;
        divisor = 1;
        for (int i = 0; i < 4; i++) begin
            digit[i] = (wrapped / divisor) % 10;
            divisor = divisor * 10;
        end
        // higher digits only when forced or the raw value reaches them
        shown = 1;
        if (beat.show_leading_zeros || beat.value > 9)   shown = 2;
        if (beat.show_leading_zeros || beat.value > 99)  shown = 3;
        if (beat.show_leading_zeros || beat.value > 999) shown = 4;
        for (int d = 0; d < shown; d++) begin
            frame = {GLYPHS[digit[d]*8 +: 8], SELECTS[d*8 +: 8]};
            for (int b = 15; b >= 0; b--) begin
                one_bit.data_bit = frame[b];
                one_bit.latch    = (b == 0);
                one_bit.last     = (b == 0) && (d == shown - 1);
                expected_bits.push_back(one_bit);
            end
        end
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_pass(s_payload);
            if (m_valid && m_ready) begin
                beats_seen++;
                if (expected_bits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected beat %0d: data_bit=%0b latch=%0b last=%0b",
                                 beats_seen, m_payload.data_bit, m_payload.latch,
                                 m_payload.last);
                end else begin
                    want = expected_bits.pop_front();
                    if (m_payload.data_bit !== want.data_bit ||
                        m_payload.latch !== want.latch ||
                        m_payload.last !== want.last) begin
                        mismatches++;
                        // bits listed as data_bit, latch, last
                        if (mismatches <= 10)
                            $display("Beat %0d mismatch: expected %0b%0b%0b, got %0b%0b%0b",
                                     beats_seen, want.data_bit, want.latch, want.last,
                                     m_payload.data_bit, m_payload.latch,
                                     m_payload.last);
                    end
                end
            end
        end
        pending        <= expected_bits.size();
        mismatch_count <= mismatches;
        beat_count     <= beats_seen;
    end

endmodule

`default_nettype wire

// ----- sim/tb_four_digit_seven_segment_serializer.sv -----
// ----------------------------------------------------------------------------
// tb_four_digit_seven_segment_serializer
// Drives values into the serializer (edge values first, then random values
// over the whole 14-bit range) under three sender/receiver stall patterns,
// and lets fdss_scoreboard score the serial output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_digit_seven_segment_serializer;
    import fdss_pkg::*;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    fdss_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    fdss_out_t m_payload;

    int mismatch_count;
    int pending;
    int beat_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int values_sent = 0;

    always #5 aclk = ~aclk;

    four_digit_seven_segment_serializer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    fdss_scoreboard chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .beat_count     (beat_count)
    );

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // One input beat, with optional idle cycles in front of it
    task automatic send_value(input int value, input bit keep_zeros);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid                      <= 1'b1;
        s_payload.value              <= VALUE_W'(value);
        s_payload.show_leading_zeros <= keep_zeros;
        do @(posedge aclk); while (!s_ready);
        values_sent++;
    endtask

    // Hold the sender off until the display passes so far are all out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Random values, weighted so every digit count and the wrap range show up
    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        int value;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(5))
                0:       value = $urandom_range(9);
                1:       value = $urandom_range(99, 10);
                2:       value = $urandom_range(999, 100);
                3:       value = $urandom_range(9999, 1000);
                4:       value = $urandom_range(16383, 10000);
                default: value = $urandom_range(16383);
            endcase
            send_value(value, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: digit-count boundaries, all glyphs, wrap above 9999
        tx_idle_pct = 28;
        rx_idle_pct = 45;
        send_value(0, 1'b0);
        send_value(0, 1'b1);
        send_value(9, 1'b0);
        send_value(10, 1'b0);
        send_value(99, 1'b0);
        send_value(100, 1'b0);
        send_value(999, 1'b0);
        send_value(1000, 1'b0);
        send_value(9999, 1'b0);
        send_value(9999, 1'b1);
        send_value(7, 1'b1);
        send_value(42, 1'b1);
        send_value(305, 1'b0);
        send_value(1234, 1'b1);
        send_value(5678, 1'b0);
        send_value(10000, 1'b0);
        send_value(10009, 1'b0);
        send_value(12345, 1'b1);
        send_value(16383, 1'b0);
        send_value(16383, 1'b1);
        wait_for_drain();

        run_random(120, 28, 45);
        wait_for_drain();
        run_random(120, 45, 28);
        run_random(110, 0, 0);
        s_valid <= 1'b0;

        // Let the last pass finish, then watch for stray beats
        do @(posedge aclk); while (pending != 0);
        repeat (32) @(posedge aclk);

        $display("Covered %0d values (digit-count edges, leading-zero flag, wrap range)",
                 values_sent);
        $display("Checked %0d serial beats under three stall patterns", beat_count);
        if (mismatch_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/fdss_pkg.sv
sv/fdss_queue.sv
sv/fdss_front.sv
sv/fdss_back.sv
sv/four_digit_seven_segment_serializer.sv
sv/fdss_checker.sv
sim/fdss_checker.sv
sim/tb_four_digit_seven_segment_serializer.sv
